// File: rtl/core/ssg_pkg.sv
// Package for the steering safety gate: widths, register and verdict codes,
// fold and CORDIC constants, and the structs passed between the lane, merge and divider.
// No dependencies.
`default_nettype none

package ssg_pkg;

  localparam int WHEEL_COUNT      = 4;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int DRIVE_BITS_DEF   = 24;
  localparam int ATAN_ENTRIES     = 24;

  localparam int ANG_W      = 17;   // measured angle
  localparam int ANGI_W     = 18;   // angle after polarity inversion
  localparam int LIM_W      = 16;   // one packed limit
  localparam int DIM_W      = 12;   // half wheelbase / half track
  localparam int ERR_W      = 16;
  localparam int VERD_W     = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int LIMIT_MARGIN = 5;

  // CORDIC datapath in Q2.30
  localparam int CW = 34;
  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

  // angle fold and conversion to radians: z = m*Q0 + floor((m*QREM + 9000) / 18000)
  localparam int FULL_TURN  = 36000;
  localparam int HALF_TURN  = 18000;
  localparam int QUARTER    = 9000;
  localparam int FOLD_Q0    = 187403;
  localparam int FOLD_QREM  = 5426;
  localparam int RECIP_SH   = 42;
  localparam logic [27:0] RECIP_18000 = 28'd244335918;   // ceil(2^42 / 18000)

  // merge and divider widths
  localparam int R_W   = 25;   // a*a + b*b
  localparam int NUM_W = 60;   // residual numerator
  localparam int DIV_SH = 19;  // divisor is r * 2^19

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_INVERT  = 3'd0,
    REG_MIN     = 3'd1,
    REG_MAX     = 3'd2,
    REG_HALF_WB = 3'd3,
    REG_HALF_TR = 3'd4,
    REG_THRESH  = 3'd5,
    REG_COH_EN  = 3'd6
  } cfg_reg_t;

  typedef enum logic [VERD_W-1:0] {
    VERD_PASS  = 2'd0,
    VERD_LIMIT = 2'd1,
    VERD_INCOH = 2'd2
  } verdict_t;

  typedef struct packed {
    logic signed [15:0] c;
    logic signed [15:0] s;
    logic [30:0]        csq;   // c*c + s*s
  } lane_out_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [R_W-1:0]   r;
  } merge_out_t;

  // atan(2^-i) in Q2.30
  function automatic logic signed [CW-1:0] atan_q30(input int idx);
    logic signed [CW-1:0] v;
    case (idx)
      0:  v = 34'sd843314857;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043837;
      3:  v = 34'sd133525159;
      4:  v = 34'sd67021687;
      5:  v = 34'sd33543516;
      6:  v = 34'sd16775851;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194283;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048576;
      11: v = 34'sd524288;
      12: v = 34'sd262144;
      13: v = 34'sd131072;
      14: v = 34'sd65536;
      15: v = 34'sd32768;
      16: v = 34'sd16384;
      17: v = 34'sd8192;
      18: v = 34'sd4096;
      19: v = 34'sd2048;
      20: v = 34'sd1024;
      21: v = 34'sd512;
      22: v = 34'sd256;
      23: v = 34'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ssg_lane.sv
// One wheel lane: folds the angle, converts it to radians and runs a pipelined
// CORDIC to give cos, sin in Q1.15 and their squared sum. Depends on ssg_pkg.
`default_nettype none

module ssg_lane #(
  parameter int CORDIC_STEPS = ssg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               adv,
  input  logic signed [ssg_pkg::ANGI_W-1:0]  ang,
  output ssg_pkg::lane_out_t                 res
);
  import ssg_pkg::*;

  logic signed [19:0] tw;
  logic [17:0] t0, t1, r0, mh, mf;
  logic        neg_c, back_c;

  logic [13:0] m1_r;
  logic        neg1_r, back1_r;
  logic [30:0] mq2_r;
  logic [25:0] x2_r;
  logic        neg2_r, back2_r;
  logic [30:0] mq3_r;
  logic [11:0] qd3_r;
  logic        neg3_r, back3_r;
  logic [53:0] prod3;

  logic signed [CW-1:0] cx_r [0:CORDIC_STEPS];
  logic signed [CW-1:0] cy_r [0:CORDIC_STEPS];
  logic signed [CW-1:0] cz_r [0:CORDIC_STEPS];
  logic                 neg_r  [0:CORDIC_STEPS];
  logic                 back_r [0:CORDIC_STEPS];

  logic signed [15:0] cq, sq, c5_r, s5_r;
  logic signed [31:0] c2, s2;

  // reduce to [0, 36000) and fold into the first quadrant
  always_comb begin
    tw     = 20'(ang) + 20'sd72000;
    t0     = tw[17:0];
    t1     = (t0 >= 18'(2 * FULL_TURN)) ? t0 - 18'(2 * FULL_TURN) : t0;
    r0     = (t1 >= 18'(FULL_TURN)) ? t1 - 18'(FULL_TURN) : t1;
    neg_c  = (r0 >= 18'(HALF_TURN));
    mh     = neg_c ? 18'(FULL_TURN) - r0 : r0;
    back_c = (mh > 18'(QUARTER));
    mf     = back_c ? 18'(HALF_TURN) - mh : mh;
  end

  assign prod3 = 54'(x2_r) * 54'(RECIP_18000);

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r    <= mf[13:0];
      neg1_r  <= neg_c;
      back1_r <= back_c;
      // integer part of the radian scale and the remainder term
      mq2_r   <= 31'(31'(m1_r) * 31'(FOLD_Q0));
      x2_r    <= 26'(26'(m1_r) * 26'(FOLD_QREM) + 26'(QUARTER));
      neg2_r  <= neg1_r;
      back2_r <= back1_r;
      // remainder divided by 18000 through the reciprocal
      mq3_r   <= mq2_r;
      qd3_r   <= 12'(prod3 >> RECIP_SH);
      neg3_r  <= neg2_r;
      back3_r <= back2_r;
      // start vector
      cx_r[0]   <= GAIN_Q30;
      cy_r[0]   <= '0;
      cz_r[0]   <= $signed(CW'(mq3_r) + CW'(qd3_r));
      neg_r[0]  <= neg3_r;
      back_r[0] <= back3_r;
    end
  end

  // one rotation per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (adv) begin
        if (cz_r[i] >= 0) begin
          cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] - atan_q30(i);
        end else begin
          cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] + atan_q30(i);
        end
        neg_r[i+1]  <= neg_r[i];
        back_r[i+1] <= back_r[i];
      end
    end
  end

  function automatic logic signed [15:0] to_q15(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    logic signed [15:0]   o;
    r = (v + CW'(16384)) >>> 15;
    if (r > CW'(32767))       o = 16'sd32767;
    else if (r < -CW'(32767)) o = -16'sd32767;
    else                      o = r[15:0];
    return o;
  endfunction

  // round, saturate and unfold the signs
  always_comb begin
    cq = to_q15(cx_r[CORDIC_STEPS]);
    sq = to_q15(cy_r[CORDIC_STEPS]);
    if (back_r[CORDIC_STEPS]) cq = -cq;
    if (neg_r[CORDIC_STEPS])  sq = -sq;
  end

  assign c2 = c5_r * c5_r;
  assign s2 = s5_r * s5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      c5_r    <= cq;
      s5_r    <= sq;
      res.c   <= c5_r;
      res.s   <= s5_r;
      res.csq <= 31'(c2) + 31'(s2);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ssg_merge.sv
// Merge stage: combines the four lane vectors into the least-squares residual
// numerator r*(4*S2 - Sc^2 - Ss^2) - t^2 and the scale r = a^2 + b^2. Depends on ssg_pkg.
`default_nettype none

module ssg_merge (
  input  logic                         clk,
  input  logic                         adv,
  input  ssg_pkg::lane_out_t           lane [ssg_pkg::WHEEL_COUNT],
  input  logic [ssg_pkg::DIM_W-1:0]    half_wb,
  input  logic [ssg_pkg::DIM_W-1:0]    half_tr,
  output ssg_pkg::merge_out_t          res
);
  import ssg_pkg::*;

  logic signed [17:0] c0, c1, c2, c3, s0, s1, s2, s3;
  logic [24:0]        rr;

  logic signed [17:0] sc1_r, ss1_r, ds1_r, dc1_r;
  logic [32:0]        sq1_r;
  logic [R_W-1:0]     r1_r, r2_r, r3_r, r4_r, r5_r;

  logic signed [35:0] scp, ssp;
  logic signed [30:0] adp, bdp;
  logic [34:0]        scsq2_r, sssq2_r;
  logic [32:0]        sq2_r;
  logic signed [30:0] ad2_r, bd2_r;

  logic [36:0]        ud;
  logic signed [30:0] td;
  logic [34:0]        u3_r;
  logic [29:0]        at3_r;

  logic [42:0]        pl4_r;
  logic [41:0]        ph4_r;
  logic [29:0]        hh4_r, hl4_r, ll4_r;

  logic [NUM_W-1:0]   ru5_r, tt5_r;
  logic [NUM_W:0]     nd;

  always_comb begin
    c0 = 18'(lane[0].c); c1 = 18'(lane[1].c); c2 = 18'(lane[2].c); c3 = 18'(lane[3].c);
    s0 = 18'(lane[0].s); s1 = 18'(lane[1].s); s2 = 18'(lane[2].s); s3 = 18'(lane[3].s);
    rr = 25'(half_wb) * 25'(half_wb) + 25'(half_tr) * 25'(half_tr);
  end

  assign scp = sc1_r * sc1_r;
  assign ssp = ss1_r * ss1_r;
  assign adp = $signed({1'b0, half_wb}) * ds1_r;
  assign bdp = $signed({1'b0, half_tr}) * dc1_r;

  assign ud = {2'b00, sq2_r, 2'b00} - 37'(scsq2_r) - 37'(sssq2_r);
  assign td = ad2_r - bd2_r;

  assign nd = {1'b0, ru5_r} - {1'b0, tt5_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      // sums over the wheels
      sc1_r <= c0 + c1 + c2 + c3;
      ss1_r <= s0 + s1 + s2 + s3;
      ds1_r <= s0 + s1 - s2 - s3;
      dc1_r <= c0 - c1 + c2 - c3;
      sq1_r <= 33'(lane[0].csq) + 33'(lane[1].csq) + 33'(lane[2].csq) + 33'(lane[3].csq);
      r1_r  <= (rr == '0) ? R_W'(1) : rr;
      // squares of the sums and the rotation projections
      scsq2_r <= scp[34:0];
      sssq2_r <= ssp[34:0];
      ad2_r   <= adp;
      bd2_r   <= bdp;
      sq2_r   <= sq1_r;
      r2_r    <= r1_r;
      // translation residual and rotation term
      u3_r  <= ud[34:0];
      at3_r <= td[30] ? 30'(-td) : td[29:0];
      r3_r  <= r2_r;
      // partial products of r*u and t*t
      pl4_r <= 43'(r3_r) * 43'(u3_r[17:0]);
      ph4_r <= 42'(r3_r) * 42'(u3_r[34:18]);
      hh4_r <= 30'(at3_r[29:15]) * 30'(at3_r[29:15]);
      hl4_r <= 30'(at3_r[29:15]) * 30'(at3_r[14:0]);
      ll4_r <= 30'(at3_r[14:0]) * 30'(at3_r[14:0]);
      r4_r  <= r3_r;
      // recombine
      ru5_r <= (NUM_W'(ph4_r) << 18) + NUM_W'(pl4_r);
      tt5_r <= (NUM_W'(hh4_r) << 30) + (NUM_W'(hl4_r) << 16) + NUM_W'(ll4_r);
      r5_r  <= r4_r;
      // clamp at zero
      res.num <= nd[NUM_W] ? '0 : nd[NUM_W-1:0];
      res.r   <= r5_r;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ssg_div.sv
// Pipelined restoring divider: error = min(65535, floor(num / (r * 2^19))),
// one quotient bit per stage after a saturation check. Depends on ssg_pkg.
`default_nettype none

module ssg_div (
  input  logic                         clk,
  input  logic                         adv,
  input  ssg_pkg::merge_out_t          din,
  output logic [ssg_pkg::ERR_W-1:0]    quo
);
  import ssg_pkg::*;

  logic [NUM_W-1:0] rem_r [0:ERR_W];
  logic [R_W-1:0]   r_r   [0:ERR_W];
  logic [ERR_W-1:0] q_r   [0:ERR_W];
  logic             sat_r [0:ERR_W];

  // saturate when the quotient would need a seventeenth bit
  always_ff @(posedge clk) begin
    if (adv) begin
      sat_r[0] <= ({1'b0, din.num} >= ((NUM_W+1)'(din.r) << (DIV_SH + ERR_W)));
      rem_r[0] <= din.num;
      r_r[0]   <= din.r;
      q_r[0]   <= '0;
    end
  end

  for (genvar j = 0; j < ERR_W; j++) begin : g_bit
    localparam int SH = DIV_SH + ERR_W - 1 - j;
    logic [NUM_W:0] dsh;
    logic           ge;
    assign dsh = (NUM_W+1)'(r_r[j]) << SH;
    assign ge  = ({1'b0, rem_r[j]} >= dsh);
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[j+1] <= ge ? rem_r[j] - dsh[NUM_W-1:0] : rem_r[j];
        q_r[j+1]   <= {q_r[j][ERR_W-2:0], ge};
        r_r[j+1]   <= r_r[j];
        sat_r[j+1] <= sat_r[j];
      end
    end
  end

  assign quo = sat_r[ERR_W] ? '1 : q_r[ERR_W];

endmodule

`default_nettype wire

// File: rtl/core/steering_safety_gate.sv
// Steering safety gate top level: one item per cycle while the output is not stalled.
// The whole pipeline advances together; a stalled output holds every stage.
// Reset (rst_n low, synchronous) empties the pipeline and loads register defaults.
// Depends on ssg_pkg, ssg_lane, ssg_merge and ssg_div.
`default_nettype none

module steering_safety_gate #(
  parameter int CORDIC_STEPS = ssg_pkg::CORDIC_STEPS_DEF,
  parameter int DRIVE_BITS   = ssg_pkg::DRIVE_BITS_DEF,
  localparam int IN_W  = ((1 + 4 * 17 + 4 * DRIVE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((4 * DRIVE_BITS + 18 + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // check enable, FL, FR, RL, RR angles, then FL, FR, RL, RR drives
  input  logic [IN_W-1:0]                   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // FL, FR, RL, RR gated drives, verdict, residual error
  output logic [OUT_W-1:0]                  out_tdata,
  input  logic                              cfg_we,
  input  logic [ssg_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [ssg_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import ssg_pkg::*;

  localparam int LANE_LAT = CORDIC_STEPS + 6;
  localparam int SB_DEPTH = LANE_LAT + 6 + ERR_W + 1;
  localparam int DRV_W    = WHEEL_COUNT * DRIVE_BITS;
  localparam int SB_W     = 3 + DRV_W;
  localparam int DRV_LSB  = 1 + WHEEL_COUNT * ANG_W;

  // configuration
  logic [WHEEL_COUNT-1:0] inv_r;
  logic [63:0]            min_r, max_r;
  logic [DIM_W-1:0]       hwb_r, htr_r;
  logic [ERR_W-1:0]       thr_r;
  logic                   coh_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r    <= '0;
      min_r    <= 64'h8000800080008000;
      max_r    <= 64'h7FFF7FFF7FFF7FFF;
      hwb_r    <= DIM_W'(500);
      htr_r    <= DIM_W'(400);
      thr_r    <= '1;
      coh_en_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_INVERT:  inv_r    <= cfg_wdata[WHEEL_COUNT-1:0];
        REG_MIN:     min_r    <= cfg_wdata;
        REG_MAX:     max_r    <= cfg_wdata;
        REG_HALF_WB: hwb_r    <= cfg_wdata[DIM_W-1:0];
        REG_HALF_TR: htr_r    <= cfg_wdata[DIM_W-1:0];
        REG_THRESH:  thr_r    <= cfg_wdata[ERR_W-1:0];
        REG_COH_EN:  coh_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // pipeline advances whenever the output register can take an item
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // input stage: polarity, limit check, drive test
  logic signed [ANGI_W-1:0] angi [WHEEL_COUNT];
  logic [WHEEL_COUNT-1:0]   over;
  logic                     any_drv;

  always_comb begin
    for (int w = 0; w < WHEEL_COUNT; w++) begin
      logic signed [ANG_W-1:0]  a;
      logic signed [18:0]       lo, hi, ai;
      a       = $signed(in_tdata[1 + w * ANG_W +: ANG_W]);
      angi[w] = inv_r[w] ? -ANGI_W'(a) : ANGI_W'(a);
      ai      = 19'(angi[w]);
      lo      = 19'($signed(min_r[w * LIM_W +: LIM_W])) - 19'sd5;
      hi      = 19'($signed(max_r[w * LIM_W +: LIM_W])) + 19'sd5;
      over[w] = (ai < lo) || (ai > hi);
    end
    any_drv = |in_tdata[DRV_LSB +: DRV_W];
  end

  logic signed [ANGI_W-1:0] ang0_r [WHEEL_COUNT];
  logic [SB_W-1:0]          sb0_r;
  logic                     v0_r;

  // sideband: check, fail, coherence wanted, drives
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ang0_r <= angi;
      sb0_r  <= {in_tdata[DRV_LSB +: DRV_W], coh_en_r && any_drv, |over, in_tdata[0]};
    end
  end

  // lanes
  lane_out_t lres [WHEEL_COUNT];
  for (genvar w = 0; w < WHEEL_COUNT; w++) begin : g_lane
    ssg_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane (
      .clk (clk),
      .adv (adv),
      .ang (ang0_r[w]),
      .res (lres[w])
    );
  end

  merge_out_t mres;
  ssg_merge u_merge (
    .clk     (clk),
    .adv     (adv),
    .lane    (lres),
    .half_wb (hwb_r),
    .half_tr (htr_r),
    .res     (mres)
  );

  logic [ERR_W-1:0] q;
  ssg_div u_div (
    .clk (clk),
    .adv (adv),
    .din (mres),
    .quo (q)
  );

  // delay sideband and valid alongside the datapath
  logic [SB_W-1:0] sb_r [0:SB_DEPTH-1];
  logic            vl_r [0:SB_DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SB_DEPTH; k++) vl_r[k] <= 1'b0;
    end else if (adv) begin
      vl_r[0] <= v0_r;
      for (int k = 1; k < SB_DEPTH; k++) vl_r[k] <= vl_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r[0] <= sb0_r;
      for (int k = 1; k < SB_DEPTH; k++) sb_r[k] <= sb_r[k-1];
    end
  end

  // verdict and drive gating
  logic [SB_W-1:0]  sbe;
  logic             chk, fail, coh, coh_run;
  logic [ERR_W-1:0] err;
  verdict_t         verd;

  always_comb begin
    sbe     = sb_r[SB_DEPTH-1];
    chk     = sbe[0];
    fail    = sbe[1];
    coh     = sbe[2];
    coh_run = chk && !fail && coh;
    err     = coh_run ? q : '0;
    if (!chk)                          verd = VERD_PASS;
    else if (fail)                     verd = VERD_LIMIT;
    else if (coh_run && (err > thr_r)) verd = VERD_INCOH;
    else                               verd = VERD_PASS;
  end

  logic             out_valid_r;
  logic [DRV_W-1:0] out_drv_r;
  verdict_t         out_verd_r;
  logic [ERR_W-1:0] out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vl_r[SB_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_drv_r  <= (verd == VERD_PASS) ? sbe[3 +: DRV_W] : '0;
      out_verd_r <= verd;
      out_err_r  <= err;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_err_r, out_verd_r, out_drv_r});

`ifndef SYNTH
  a_block_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_verd_r != VERD_PASS) |-> (out_drv_r == '0))
    else $error("blocked item carries nonzero drive");

  a_limit_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_verd_r == VERD_LIMIT) |-> (out_err_r == '0))
    else $error("coherence error reported after limit failure");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
`endif

endmodule

`default_nettype wire

// File: dv/steering_safety_gate_test.sv
// Self-checking testbench for steering_safety_gate: stream driver and monitor,
// a bit-exact gate predictor (limit check, CORDIC, twist residual) and phased register settings.
// Depends on ssg_pkg and the steering_safety_gate RTL.
`timescale 1ns / 1ps

module steering_safety_gate_test;
  import ssg_pkg::*;

  localparam int IN_W  = 168;
  localparam int OUT_W = 120;
  localparam int LATENCY = 47;

  typedef struct {
    bit                 chk;
    logic signed [16:0] ang [4];
    logic signed [23:0] drv [4];
  } gate_item_t;

  typedef struct {
    logic signed [23:0] drv [4];
    verdict_t           verd;
    logic [15:0]        err;
  } gate_result_t;

  logic            clk = 0;
  logic            rst_n = 0;
  logic            in_tvalid = 0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic            out_tvalid;
  logic            out_tready = 0;
  logic [OUT_W-1:0] out_tdata;
  logic            cfg_we = 0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // register shadow
  logic [3:0]  inv_mask = 4'd0;
  logic [63:0] min_lims = 64'h8000800080008000;
  logic [63:0] max_lims = 64'h7FFF7FFF7FFF7FFF;
  logic [11:0] half_wb = 12'd500;
  logic [11:0] half_tr = 12'd400;
  logic [15:0] coh_thresh = 16'hFFFF;
  bit          coh_en = 1'b1;

  gate_item_t   pending_items [$];
  gate_result_t expected_results [$];
  bit  in_took = 0;
  bit  no_idle = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  mismatches = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  verdict_count [3] = '{0, 0, 0};

  longint atan_tab [16] = '{843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768};

  steering_safety_gate dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // round Q2.30 to Q1.15 and saturate
  function automatic longint q30_to_q15(longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32767) r = -32767;
    return r;
  endfunction

  // wheel direction unit vector in Q1.15 from an angle in 0.01 degree
  task automatic wheel_dir(input longint ang, output longint c, output longint s);
    longint r, m, z, x, y, nx;
    bit neg, back;
    r = ang % 36000;
    if (r < 0) r += 36000;
    if (r >= 18000) r -= 36000;
    neg = r < 0;
    m = neg ? -r : r;
    back = m > 9000;
    if (back) m = 18000 - m;
    z = (m * 64'sd3373259426 + 9000) / 18000;
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_tab[i];
      end
      x = nx;
    end
    c = q30_to_q15(x);
    s = q30_to_q15(y);
    if (back) c = -c;
    if (neg) s = -s;
  endtask

  // normalized least-squares twist residual in unsigned Q5.11
  task automatic twist_residual(input longint ang [4], output logic [15:0] err);
    longint c [4], s [4];
    longint a, b, sc, ss, s2, t, r, num, q;
    a = half_wb;
    b = half_tr;
    sc = 0; ss = 0; s2 = 0;
    for (int i = 0; i < 4; i++) begin
      wheel_dir(ang[i], c[i], s[i]);
      sc += c[i];
      ss += s[i];
      s2 += c[i] * c[i] + s[i] * s[i];
    end
    t = a * (s[0] + s[1] - s[2] - s[3]) - b * (c[0] - c[1] + c[2] - c[3]);
    r = a * a + b * b;
    if (r == 0) r = 1;
    num = 4 * r * s2 - r * (sc * sc + ss * ss) - t * t;
    if (num < 0) num = 0;
    q = num / (r * (64'sd1 << 19));
    if (q > 65535) q = 65535;
    err = q[15:0];
  endtask

  task automatic predict_gate(input gate_item_t it, output gate_result_t res);
    longint ang [4];
    longint lo, hi;
    bit any_drive, over;
    any_drive = 0;
    over = 0;
    res.verd = VERD_PASS;
    res.err = '0;
    for (int i = 0; i < 4; i++) begin
      ang[i] = it.ang[i];
      if (inv_mask[i]) ang[i] = -ang[i];
      if (it.drv[i] != 0) any_drive = 1;
      lo = $signed(min_lims[16*i +: 16]);
      hi = $signed(max_lims[16*i +: 16]);
      if (ang[i] < lo - LIMIT_MARGIN || ang[i] > hi + LIMIT_MARGIN) over = 1;
    end
    if (it.chk) begin
      if (over) begin
        res.verd = VERD_LIMIT;
      end else if (coh_en && any_drive) begin
        twist_residual(ang, res.err);
        if (res.err > coh_thresh) res.verd = VERD_INCOH;
      end
    end
    for (int i = 0; i < 4; i++) res.drv[i] = (res.verd == VERD_PASS) ? it.drv[i] : '0;
  endtask

  function automatic logic [IN_W-1:0] pack_item(gate_item_t it);
    logic [IN_W-1:0] d;
    d = '0;
    d[0] = it.chk;
    for (int i = 0; i < 4; i++) begin
      d[1 + 17*i +: 17] = it.ang[i];
      d[69 + 24*i +: 24] = it.drv[i];
    end
    return d;
  endfunction

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // record handshakes at the rising edge; predict on acceptance
  always @(posedge clk) begin
    gate_result_t res;
    in_took = rst_n && in_tvalid && in_tready;
    if (in_took) begin
      predict_gate(pending_items.pop_front(), res);
      expected_results.push_back(res);
      items_sent++;
    end
  end

  // item driver
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_took)) begin
      if (gap_left > 0 || pending_items.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_tvalid <= 1'b0;
      end else begin
        in_tdata <= pack_item(pending_items[0]);
        in_tvalid <= 1'b1;
        gap_left = pick_gap();
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // result monitor
  always @(posedge clk) begin
    gate_result_t exp_res;
    logic signed [23:0] got_drv;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result with no expectation pending: %h", out_tdata);
        mismatches++;
      end else begin
        exp_res = expected_results.pop_front();
        verdict_count[exp_res.verd]++;
        for (int i = 0; i < 4; i++) begin
          got_drv = out_tdata[24*i +: 24];
          if (got_drv !== exp_res.drv[i]) begin
            $error("out_drive[%0d]: expected %0d, got %0d", i, exp_res.drv[i], got_drv);
            mismatches++;
          end
        end
        if (out_tdata[97:96] !== exp_res.verd) begin
          $error("verdict: expected %0d, got %0d", exp_res.verd, out_tdata[97:96]);
          mismatches++;
        end
        if (out_tdata[113:98] !== exp_res.err) begin
          $error("coh_err: expected %0d, got %0d", exp_res.err, out_tdata[113:98]);
          mismatches++;
        end
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    cfg_addr <= idx;
    cfg_wdata <= val;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_settings(logic [3:0] mask, logic [63:0] mn, logic [63:0] mx,
                               logic [11:0] a, logic [11:0] b, logic [15:0] thr, bit en);
    inv_mask = mask; min_lims = mn; max_lims = mx;
    half_wb = a; half_tr = b; coh_thresh = thr; coh_en = en;
    write_reg(REG_INVERT, 64'(mask));
    write_reg(REG_MIN, mn);
    write_reg(REG_MAX, mx);
    write_reg(REG_HALF_WB, 64'(a));
    write_reg(REG_HALF_TR, 64'(b));
    write_reg(REG_THRESH, 64'(thr));
    write_reg(REG_COH_EN, 64'(en));
  endtask

  task automatic wait_drained();
    wait (pending_items.size() == 0 && !in_tvalid && expected_results.size() == 0);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  function automatic logic signed [23:0] rand_drive();
    case ($urandom_range(0, 5))
      0: return 24'sd0;
      1: return 24'($signed($urandom_range(0, 15)) - 8);
      default: return 24'($urandom);
    endcase
  endfunction

  // random item: mostly a coherent twist with small noise, else noise and odd cases
  function automatic gate_item_t rand_item();
    gate_item_t it;
    real vx, vy, w, wx, wy, deg;
    real px [4], py [4];
    longint a16;
    int kind;
    kind = $urandom_range(0, 9);
    it.chk = (kind != 9);
    for (int i = 0; i < 4; i++) it.drv[i] = (kind == 8) ? 24'sd0 : rand_drive();
    px = '{real'(half_wb), real'(half_wb), -real'(half_wb), -real'(half_wb)};
    py = '{real'(half_tr), -real'(half_tr), real'(half_tr), -real'(half_tr)};
    vx = ($urandom_range(0, 2000) - 1000.0) / 1000.0;
    vy = ($urandom_range(0, 2000) - 1000.0) / 1000.0;
    w = ($urandom_range(0, 2000) - 1000.0) / (1000.0 * (half_wb + half_tr + 1));
    for (int i = 0; i < 4; i++) begin
      if (kind <= 5) begin
        wx = vx - w * py[i];
        wy = vy + w * px[i];
        deg = $atan2(wy, wx) * 18000.0 / 3.14159265358979;
        a16 = longint'(deg) + $signed($urandom_range(0, 6)) - 3;
        if ($urandom_range(0, 7) == 0) a16 += ($urandom_range(0, 1) ? 36000 : -36000);
        if (inv_mask[i]) a16 = -a16;
        it.ang[i] = 17'(a16);
      end else if (kind == 6) begin
        it.ang[i] = 17'($urandom);
      end else begin
        it.ang[i] = 17'($signed($urandom_range(0, 72000)) - 36000);
      end
    end
    return it;
  endfunction

  function automatic gate_item_t make_item(bit chk, int a0, int a1, int a2, int a3,
                                           int d0, int d1, int d2, int d3);
    gate_item_t it;
    it.chk = chk;
    it.ang = '{17'(a0), 17'(a1), 17'(a2), 17'(a3)};
    it.drv = '{24'(d0), 24'(d1), 24'(d2), 24'(d3)};
    return it;
  endfunction

  initial begin
    int phase_items;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed items under reset settings
    pending_items.push_back(make_item(1, 0, 0, 0, 0, 1, 1, 1, 1));
    pending_items.push_back(make_item(0, 65535, -65536, 0, 0, 8388607, -8388608, 5, 0));
    pending_items.push_back(make_item(1, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(1, 32772, -32773, 0, 0, 9, 9, 9, 9));
    pending_items.push_back(make_item(1, 32773, 0, 0, 0, 9, 9, 9, 9));
    pending_items.push_back(make_item(1, 0, 0, 0, -32774, 9, 9, 9, 9));
    pending_items.push_back(make_item(1, 9000, 9000, 9000, 9000, -1, 2, 3, 4));
    pending_items.push_back(make_item(1, 18000, -18000, 36000, -36000, 7, 7, 7, 7));
    pending_items.push_back(make_item(1, 9000, -9000, 27000, 4500, 8388607, 1, 1, 1));
    pending_items.push_back(make_item(1, 35999, -35999, 17999, -17999, 3, 3, 3, 3));
    pending_items.push_back(make_item(1, 65535, 65535, 65535, 65535, -8388608, 0, 0, 0));
    wait_drained();

    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: load_settings(4'h0, 64'h8000800080008000, 64'h7FFF7FFF7FFF7FFF, 12'd500, 12'd400,
                         16'd2000, 1'b1);
        1: load_settings(4'hF, 64'hDCD8DCD8DCD8DCD8, 64'h2328232823282328, 12'd1, 12'd4095,
                         16'd0, 1'b1);
        2: load_settings(4'h5, {16'(-12000), 16'(-9000), 16'(-20000), 16'(-3000)},
                         {16'(12000), 16'(9000), 16'(20000), 16'(3000)}, 12'd4095, 12'd1,
                         16'd65535, 1'b1);
        3: load_settings(4'hA, 64'h7FFF7FFF7FFF7FFF, 64'h8000800080008000, 12'd4095,
                         12'd4095, 16'd100, 1'b1);
        4: load_settings(4'h3, 64'h8000800080008000, 64'h7FFF7FFF7FFF7FFF, 12'd0, 12'd0,
                         16'd500, 1'b1);
        5: load_settings(4'hC, 64'h8000800080008000, 64'h7FFF7FFF7FFF7FFF, 12'd700, 12'd350,
                         16'd50, 1'b0);
        6: load_settings(4'($urandom), {$urandom, $urandom} | 64'h8000800080008000,
                         {$urandom, $urandom} & 64'h7FFF7FFF7FFF7FFF,
                         12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)),
                         16'($urandom), 1'b1);
        default: load_settings(4'($urandom), 64'h8000800080008000, 64'h7FFF7FFF7FFF7FFF,
                               12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)),
                               16'($urandom_range(0, 3000)), 1'b1);
      endcase
      no_idle = (phase == 2);
      phase_items = 110;
      for (int n = 0; n < phase_items; n++) pending_items.push_back(rand_item());
      wait_drained();
    end

    $display("Sent %0d items, checked %0d results over 10 register settings.",
             items_sent, results_seen);
    $display("Verdicts seen: %0d passed, %0d over limit, %0d incoherent.",
             verdict_count[0], verdict_count[1], verdict_count[2]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/ssg_pkg.sv
rtl/core/ssg_lane.sv
rtl/core/ssg_merge.sv
rtl/core/ssg_div.sv
rtl/core/steering_safety_gate.sv
dv/steering_safety_gate_test.sv
